[rtl/sts_pkg.sv]
package sts_pkg;

  // Table geometry
  localparam int CAPACITY = 256;
  localparam int TAG_W    = 32;
  localparam int RANK_W   = 9;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int KIND_W   = 3;
  localparam int STAT_W   = 2;

  // Match reduction: cells are gathered in groups, one registered level per group
  localparam int GRP_N    = 16;
  localparam int GRP_SIZE = CAPACITY / GRP_N;
  localparam int GRP_W    = $clog2(GRP_N);
  localparam int SLOT_W   = $clog2(GRP_SIZE);

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD          = 3'd0,
    KIND_DEL_VALUE    = 3'd1,
    KIND_DEL_RANK     = 3'd2,
    KIND_FIND_EXACT   = 3'd3,
    KIND_FIND_CLOSEST = 3'd4,
    KIND_READ_RANK    = 3'd5
  } kind_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_DONE = 2'd0,
    STAT_MISS = 2'd1,
    STAT_FULL = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CMD_HOLD   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_REMOVE = 2'd2
  } cell_op_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_EVAL  = 2'd1,
    ST_APPLY = 2'd2
  } state_e;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [TAG_W-1:0]  tag_value;
    logic [RANK_W-1:0] tag_rank;
  } req_t;

  typedef struct packed {
    logic [RANK_W-1:0] found_rank;
    logic [TAG_W-1:0]  found_value;
    logic [RANK_W-1:0] entries_held;
    logic [STAT_W-1:0] status;
  } res_t;

  // Broadcast to every cell: compare value and current fill
  typedef struct packed {
    logic [TAG_W-1:0]  value;
    logic [RANK_W-1:0] total;
  } probe_t;

  // Broadcast to every cell: shift or load command
  typedef struct packed {
    cell_op_e         op;
    logic [IDX_W-1:0] pos;
    logic [TAG_W-1:0] value;
  } cell_cmd_t;

  typedef struct packed {
    logic lt;
    logic eq;
  } cell_flag_t;

  // One group's share of the match reduction
  typedef struct packed {
    logic              any_eq;
    logic [RANK_W-1:0] below;
    logic [TAG_W-1:0]  sel_value;
  } grp_sum_t;

endpackage

[rtl/sts_cell.sv]
module sts_cell (
  input  logic                        clk_i,
  input  logic [sts_pkg::IDX_W-1:0]   idx_i,
  input  sts_pkg::probe_t             probe_i,
  input  sts_pkg::cell_cmd_t          cmd_i,
  input  logic [sts_pkg::TAG_W-1:0]   left_i,
  input  logic [sts_pkg::TAG_W-1:0]   right_i,
  output logic [sts_pkg::TAG_W-1:0]   entry_o,
  output sts_pkg::cell_flag_t         flag_o
);
  import sts_pkg::*;

  logic [TAG_W-1:0] entry_q, entry_d;
  logic             valid;

  // Compare the held entry against the probe; cells past the fill never match
  always_comb begin
    valid     = {1'b0, idx_i} < probe_i.total;
    flag_o.lt = valid && (entry_q < probe_i.value);
    flag_o.eq = valid && (entry_q == probe_i.value);
  end

  // Open a gap, load the new tag, or close a gap from the upper neighbor
  always_comb begin
    entry_d = entry_q;
    case (cmd_i.op)
      CMD_INSERT: begin
        if (idx_i > cmd_i.pos) begin
          entry_d = left_i;
        end else if (idx_i == cmd_i.pos) begin
          entry_d = cmd_i.value;
        end
      end
      CMD_REMOVE: begin
        if (idx_i >= cmd_i.pos) begin
          entry_d = right_i;
        end
      end
      default: entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

[rtl/sts_group.sv]
module sts_group (
  input  logic                                             clk_i,
  input  logic [sts_pkg::GRP_W-1:0]                        grp_i,
  input  sts_pkg::cell_flag_t [sts_pkg::GRP_SIZE-1:0]      flags_i,
  input  logic                                             lt_next_i,
  input  logic [sts_pkg::GRP_SIZE-1:0][sts_pkg::TAG_W-1:0] ent_i,
  input  logic [sts_pkg::RANK_W-1:0]                       rank_i,
  input  logic                                             use_rank_i,
  output sts_pkg::grp_sum_t                                sum_o
);
  import sts_pkg::*;

  grp_sum_t          sum_d, sum_q;
  logic [GRP_SIZE:0] lt_ext;

  // Gather the below flags of this group plus the first cell of the next group
  always_comb begin
    for (int k = 0; k < GRP_SIZE; k++) begin
      lt_ext[k] = flags_i[k].lt;
    end
    lt_ext[GRP_SIZE] = lt_next_i;
  end

  // Find the last cell below the probe and the selected entry in this group
  always_comb begin
    logic [IDX_W-1:0]  idx;
    logic [RANK_W-1:0] rank1;
    logic              edge_hit;
    logic              hit;
    sum_d = '0;
    for (int j = 0; j < GRP_SIZE; j++) begin
      idx      = {grp_i, SLOT_W'(j)};
      rank1    = {1'b0, idx} + RANK_W'(1);
      edge_hit = lt_ext[j] && !lt_ext[j+1];
      hit      = use_rank_i ? (rank_i == rank1) : edge_hit;
      sum_d.any_eq = sum_d.any_eq | flags_i[j].eq;
      if (edge_hit) begin
        sum_d.below = sum_d.below | rank1;
      end
      if (hit) begin
        sum_d.sel_value = sum_d.sel_value | ent_i[j];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
  end

  assign sum_o = sum_q;

endmodule

[rtl/sorted_tag_set_top.sv]
// Channel  | Direction | Handshake            | Payload
// request  | in        | start / busy         | req_i  (kind, tag_value, tag_rank)
// result   | out       | done_o (one cycle)   | res_o  (found_rank, found_value,
//          |           |                      |         entries_held, status)
//
// Each item passes capture, a compare state (ST_EVAL) in which all cells compare
// in parallel and each group of cells registers its partial match, and an apply
// state (ST_APPLY) that merges the groups, decides, and shifts the cell row.
// done_o pulses in the cycle after ST_APPLY, when busy is already low again.
// Reset (rst_ni low, asynchronous) empties the table; entry storage is not
// cleared, cells past the fill count are ignored.
// The receiver cannot stall: done_o marks each result for exactly one cycle.
module sorted_tag_set_top (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  input  sts_pkg::req_t   req_i,
  output logic            busy,
  output logic            done_o,
  output sts_pkg::res_t   res_o
);
  import sts_pkg::*;

  state_e            state_q, state_d;
  req_t              req_q;
  res_t              res_q, res_d;
  logic              done_q;
  logic [RANK_W-1:0] total_q, total_d;

  probe_t                          probe;
  cell_cmd_t                       cmd, cell_cmd;
  cell_flag_t [CAPACITY-1:0]       flag;
  logic [CAPACITY-1:0][TAG_W-1:0]  ent;
  logic [CAPACITY:0]               lt_ext;
  grp_sum_t                        sum [GRP_N];
  logic                            use_rank;

  logic              any_eq;
  logic [RANK_W-1:0] below;
  logic [TAG_W-1:0]  sel_value;
  logic              rank_ok;

  assign busy = (state_q != ST_IDLE);

  // Sequence one item through compare and apply
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (start) state_d = ST_EVAL;
      ST_EVAL:  state_d = ST_APPLY;
      ST_APPLY: state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      total_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == ST_APPLY);
      if (state_q == ST_APPLY) begin
        total_q <= total_d;
      end
    end
  end

  // Hold the request and the result
  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      req_q <= req_i;
    end
    if (state_q == ST_APPLY) begin
      res_q <= res_d;
    end
  end

  assign probe.value = req_q.tag_value;
  assign probe.total = total_q;
  assign use_rank = (req_q.kind == KIND_DEL_RANK) || (req_q.kind == KIND_READ_RANK);
  assign cell_cmd = (state_q == ST_APPLY) ? cmd
                  : cell_cmd_t'{op: CMD_HOLD, pos: '0, value: req_q.tag_value};

  // Row of cells, each linked to both neighbors
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [TAG_W-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_left
      assign left = ent[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_right
      assign right = ent[i+1];
    end
    sts_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (IDX_W'(i)),
      .probe_i (probe),
      .cmd_i   (cell_cmd),
      .left_i  (left),
      .right_i (right),
      .entry_o (ent[i]),
      .flag_o  (flag[i])
    );
    assign lt_ext[i] = flag[i].lt;
  end
  assign lt_ext[CAPACITY] = 1'b0;

  // First level of the match reduction, one group of cells each
  for (genvar g = 0; g < GRP_N; g++) begin : g_grp
    sts_group u_group (
      .clk_i      (clk_i),
      .grp_i      (GRP_W'(g)),
      .flags_i    (flag[g*GRP_SIZE +: GRP_SIZE]),
      .lt_next_i  (lt_ext[(g+1)*GRP_SIZE]),
      .ent_i      (ent[g*GRP_SIZE +: GRP_SIZE]),
      .rank_i     (req_q.tag_rank),
      .use_rank_i (use_rank),
      .sum_o      (sum[g])
    );
  end

  // Merge the group partials
  always_comb begin
    any_eq    = 1'b0;
    below     = '0;
    sel_value = '0;
    for (int g = 0; g < GRP_N; g++) begin
      any_eq    = any_eq | sum[g].any_eq;
      below     = below | sum[g].below;
      sel_value = sel_value | sum[g].sel_value;
    end
  end

  assign rank_ok = (req_q.tag_rank != '0) && (req_q.tag_rank <= total_q);

  // Decide the result and the cell command
  always_comb begin
    res_d        = '0;
    res_d.status = STAT_MISS;
    cmd          = '{op: CMD_HOLD, pos: '0, value: req_q.tag_value};
    total_d      = total_q;
    unique case (req_q.kind)
      KIND_ADD: begin
        if (req_q.tag_value != '0) begin
          if (any_eq) begin
            res_d.found_rank  = below + RANK_W'(1);
            res_d.found_value = req_q.tag_value;
          end else if (total_q == RANK_W'(CAPACITY)) begin
            res_d.status = STAT_FULL;
          end else begin
            cmd.op            = CMD_INSERT;
            cmd.pos           = below[IDX_W-1:0];
            total_d           = total_q + RANK_W'(1);
            res_d.found_rank  = below + RANK_W'(1);
            res_d.found_value = req_q.tag_value;
            res_d.status      = STAT_DONE;
          end
        end
      end
      KIND_DEL_VALUE: begin
        if (any_eq) begin
          cmd.op            = CMD_REMOVE;
          cmd.pos           = below[IDX_W-1:0];
          total_d           = total_q - RANK_W'(1);
          res_d.found_rank  = below + RANK_W'(1);
          res_d.found_value = req_q.tag_value;
          res_d.status      = STAT_DONE;
        end
      end
      KIND_DEL_RANK: begin
        if (rank_ok) begin
          cmd.op            = CMD_REMOVE;
          cmd.pos           = IDX_W'(req_q.tag_rank - RANK_W'(1));
          total_d           = total_q - RANK_W'(1);
          res_d.found_rank  = req_q.tag_rank;
          res_d.found_value = sel_value;
          res_d.status      = STAT_DONE;
        end
      end
      KIND_FIND_EXACT: begin
        if (any_eq) begin
          res_d.found_rank  = below + RANK_W'(1);
          res_d.found_value = req_q.tag_value;
          res_d.status      = STAT_DONE;
        end
      end
      KIND_FIND_CLOSEST: begin
        if (req_q.tag_value != '0) begin
          if (any_eq) begin
            res_d.found_rank  = below + RANK_W'(1);
            res_d.found_value = req_q.tag_value;
            res_d.status      = STAT_DONE;
          end else if (below != '0) begin
            res_d.found_rank  = below;
            res_d.found_value = sel_value;
            res_d.status      = STAT_DONE;
          end
        end
      end
      KIND_READ_RANK: begin
        if (rank_ok) begin
          res_d.found_rank  = req_q.tag_rank;
          res_d.found_value = sel_value;
          res_d.status      = STAT_DONE;
        end
      end
      default: ;
    endcase
    res_d.entries_held = total_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  // Checks
  a_done_after_apply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q) == ST_APPLY)
    else $error("result strobe without an apply cycle");

  a_accept_to_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> state_q == ST_EVAL)
    else $error("accepted item did not enter compare");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= RANK_W'(CAPACITY))
    else $error("fill count above capacity");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.status == STAT_FULL) |-> res_o.entries_held == RANK_W'(CAPACITY))
    else $error("table full reported below capacity");

  a_no_rank_no_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.found_rank == '0) |-> res_o.found_value == '0)
    else $error("value given without a rank");

endmodule

[tb/tag_set_checker.sv]
`timescale 1ns / 1ps

module tag_set_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          busy_i,
  input  sts_pkg::req_t req_i,
  input  logic          done_i,
  input  sts_pkg::res_t res_i,
  output int            fail_count_o,
  output int            pending_o
);
  import sts_pkg::*;

  // Shadow copy of the sorted table
  logic [TAG_W-1:0] shadow_tags [CAPACITY];
  int               shadow_fill = 0;

  // Results owed by the block, oldest first
  res_t             expected_results [$];
  res_t             oldest_result;
  int               mismatches = 0;
  int               owed = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = owed;

  // Number of held tags strictly below v, i.e. the insert position
  function automatic int tags_below(input logic [TAG_W-1:0] v);
    int n;
    n = 0;
    while (n < shadow_fill && shadow_tags[n] < v) n++;
    return n;
  endfunction

  // One-based rank of v, 0 when v is zero or not held
  function automatic int rank_of(input logic [TAG_W-1:0] v);
    int p;
    if (v == '0) return 0;
    p = tags_below(v);
    if (p < shadow_fill && shadow_tags[p] == v) return p + 1;
    return 0;
  endfunction

  // Close the gap left by the tag at one-based rank r
  function automatic void drop_rank(input int r);
    int i;
    for (i = r - 1; i + 1 < shadow_fill; i++) shadow_tags[i] = shadow_tags[i + 1];
    shadow_fill--;
  endfunction

  // Apply one request to the shadow table and return the result it yields
  function automatic res_t apply_request(input req_t r);
    res_t o;
    int   pos;
    int   rnk;
    int   i;
    o        = '0;
    o.status = STAT_MISS;
    rnk      = 0;
    case (r.kind)
      KIND_ADD: begin
        if (r.tag_value != '0) begin
          pos = tags_below(r.tag_value);
          if (pos < shadow_fill && shadow_tags[pos] == r.tag_value) begin
            rnk           = pos + 1;
            o.found_value = r.tag_value;
          end else if (shadow_fill >= CAPACITY) begin
            o.status = STAT_FULL;
          end else begin
            for (i = shadow_fill; i > pos; i--) shadow_tags[i] = shadow_tags[i - 1];
            shadow_tags[pos] = r.tag_value;
            shadow_fill++;
            rnk           = pos + 1;
            o.found_value = r.tag_value;
            o.status      = STAT_DONE;
          end
        end
      end
      KIND_DEL_VALUE: begin
        rnk = rank_of(r.tag_value);
        if (rnk != 0) begin
          o.found_value = shadow_tags[rnk - 1];
          drop_rank(rnk);
          o.status = STAT_DONE;
        end
      end
      KIND_DEL_RANK: begin
        if (r.tag_rank != '0 && int'(r.tag_rank) <= shadow_fill) begin
          rnk           = int'(r.tag_rank);
          o.found_value = shadow_tags[rnk - 1];
          drop_rank(rnk);
          o.status = STAT_DONE;
        end
      end
      KIND_FIND_EXACT: begin
        rnk = rank_of(r.tag_value);
        if (rnk != 0) begin
          o.found_value = shadow_tags[rnk - 1];
          o.status      = STAT_DONE;
        end
      end
      KIND_FIND_CLOSEST: begin
        if (r.tag_value != '0) begin
          pos = tags_below(r.tag_value);
          if (pos < shadow_fill && shadow_tags[pos] == r.tag_value) rnk = pos + 1;
          else rnk = pos;
          if (rnk != 0) begin
            o.found_value = shadow_tags[rnk - 1];
            o.status      = STAT_DONE;
          end
        end
      end
      KIND_READ_RANK: begin
        if (r.tag_rank != '0 && int'(r.tag_rank) <= shadow_fill) begin
          rnk           = int'(r.tag_rank);
          o.found_value = shadow_tags[rnk - 1];
          o.status      = STAT_DONE;
        end
      end
      default: begin
        // spare kinds do nothing
      end
    endcase
    o.found_rank   = RANK_W'(rnk);
    o.entries_held = RANK_W'(shadow_fill);
    return o;
  endfunction

  function automatic void compare_field(input string name, input logic [TAG_W-1:0] want,
                                        input logic [TAG_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Retire the oldest owed result first, then take in the new item
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shadow_fill = 0;
      expected_results.delete();
    end else begin
      if (done_i) begin
        if (expected_results.size() == 0) begin
          $error("result arrived with no item outstanding");
          mismatches++;
        end else begin
          oldest_result = expected_results.pop_front();
          compare_field("found_rank", TAG_W'(oldest_result.found_rank),
                        TAG_W'(res_i.found_rank));
          compare_field("found_value", oldest_result.found_value, res_i.found_value);
          compare_field("entries_held", TAG_W'(oldest_result.entries_held),
                        TAG_W'(res_i.entries_held));
          compare_field("status", TAG_W'(oldest_result.status), TAG_W'(res_i.status));
        end
      end
      if (start_i && !busy_i) expected_results.push_back(apply_request(req_i));
    end
    owed = expected_results.size();
  end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
  import sts_pkg::*;

  localparam int WATCHDOG_LIMIT = 200;
  localparam logic [KIND_W-1:0] KIND_SPARE_6 = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_7 = 3'd7;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start = 1'b0;
  req_t             req = '0;
  logic             busy;
  logic             done;
  res_t             res;

  logic             took = 1'b0;
  logic [RANK_W-1:0] held_hint = '0;
  int               idle_cycles = 0;
  int               fail_count;
  int               pending;
  bit               no_gaps = 1'b0;
  logic [TAG_W-1:0] tag_pool [$];

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  sorted_tag_set_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .req_i  (req),
    .busy   (busy),
    .done_o (done),
    .res_o  (res)
  );

  tag_set_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .req_i        (req),
    .done_i       (done),
    .res_i        (res),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Flag acceptance and track the fill level for rank picking
  always @(posedge clk_i) begin
    took <= start && !busy;
    if (done) held_hint <= res.entries_held;
  end

  // Abort when nothing moves for too long
  always @(posedge clk_i) begin
    if ((start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[sorted_tag_set_top] ERROR");
      $finish;
    end
  end

  // Offer one item after a random gap and hold it until taken
  task automatic send_item(input logic [KIND_W-1:0] kind, input logic [TAG_W-1:0] value,
                           input logic [RANK_W-1:0] rank);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start <= 1'b1;
    req   <= '{kind: kind, tag_value: value, tag_rank: rank};
    do @(negedge clk_i); while (!took);
    if (kind == KIND_ADD && value != '0) begin
      tag_pool.push_back(value);
      if (tag_pool.size() > 300) void'(tag_pool.pop_front());
    end
  endtask

  // Mix of zero, all-ones, near-held, small-window and full-range tags
  function automatic logic [TAG_W-1:0] pick_tag(input int window);
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 10) return '1;
    if (r < 25 && tag_pool.size() != 0) return tag_pool[$urandom_range(0, tag_pool.size() - 1)];
    if (r < 30 && tag_pool.size() != 0)
      return tag_pool[$urandom_range(0, tag_pool.size() - 1)] + $urandom_range(0, 2) - 1;
    if (r < 60) return $urandom_range(1, window);
    return $urandom();
  endfunction

  // Mostly ranks within the current fill, plus zero, the top rank and strays
  function automatic logic [RANK_W-1:0] pick_rank();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 16) return RANK_W'(CAPACITY);
    if (r < 80 && held_hint != '0) return RANK_W'($urandom_range(1, held_hint));
    return RANK_W'($urandom_range(0, CAPACITY));
  endfunction

  function automatic logic [KIND_W-1:0] pick_kind(input int add_pct, input int del_pct);
    int r;
    int s;
    r = $urandom_range(0, 99);
    if (r < add_pct) return KIND_ADD;
    if (r < add_pct + del_pct) return $urandom_range(0, 1) ? KIND_DEL_VALUE : KIND_DEL_RANK;
    s = $urandom_range(0, 49);
    if (s < 16) return KIND_FIND_EXACT;
    if (s < 32) return KIND_FIND_CLOSEST;
    if (s < 48) return KIND_READ_RANK;
    return $urandom_range(0, 1) ? KIND_SPARE_6 : KIND_SPARE_7;
  endfunction

  // Random items with a given operation mix; toggle back-to-back stretches
  task automatic run_phase(input int count, input int add_pct, input int del_pct,
                           input int window);
    int n;
    for (n = 0; n < count; n++) begin
      if (n % 50 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      send_item(pick_kind(add_pct, del_pct), pick_tag(window), pick_rank());
    end
  endtask

  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty table lookups
    send_item(KIND_READ_RANK, '0, 9'd1);
    send_item(KIND_FIND_CLOSEST, 32'd5, '0);
    send_item(KIND_DEL_RANK, '0, 9'd1);
    // add zero, extremes and a duplicate
    send_item(KIND_ADD, '0, '0);
    send_item(KIND_ADD, '1, '0);
    send_item(KIND_ADD, 32'd1, '1);
    send_item(KIND_ADD, 32'h8000_0000, '0);
    send_item(KIND_ADD, 32'd1, '0);
    // exact and closest finds: hit, zero, miss
    send_item(KIND_FIND_EXACT, 32'd1, '0);
    send_item(KIND_FIND_EXACT, '0, '0);
    send_item(KIND_FIND_EXACT, 32'd2, '0);
    send_item(KIND_FIND_CLOSEST, '0, '0);
    send_item(KIND_FIND_CLOSEST, 32'h7FFF_FFFF, '0);
    send_item(KIND_FIND_CLOSEST, '1, '0);
    // nothing at or below the probe after the lowest goes
    send_item(KIND_DEL_VALUE, 32'd1, '0);
    send_item(KIND_FIND_CLOSEST, 32'd5, '0);
    // rank zero, rank past the fill, a good rank
    send_item(KIND_READ_RANK, '0, '0);
    send_item(KIND_READ_RANK, '1, 9'd256);
    send_item(KIND_READ_RANK, '0, 9'd2);
    send_item(KIND_DEL_RANK, '0, 9'd3);
    send_item(KIND_DEL_RANK, '0, 9'd1);
    // spare kinds do nothing
    send_item(KIND_SPARE_6, 32'hDEAD_BEEF, 9'd1);
    send_item(KIND_SPARE_7, '1, '1);
    send_item(KIND_DEL_VALUE, '1, '0);
    send_item(KIND_DEL_VALUE, 32'd7, '0);

    // fill past capacity, hammer the full table, drain, then mix
    run_phase(420, 92, 3, 4000);
    run_phase(80, 60, 0, 4000);
    run_phase(360, 5, 75, 300);
    run_phase(420, 40, 30, 300);

    start <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    if (fail_count == 0) $display("[sorted_tag_set_top] OK");
    else $display("[sorted_tag_set_top] ERROR");
    $finish;
  end

endmodule
